>>> hdl/mrukl_pkg.sv
// shared sizes, codes and state type for the keyed record list
`default_nettype none

package mrukl_pkg;

  localparam int DEPTH        = 16;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 64;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int REC_W = KEY_BITS + PAYLOAD_BITS;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_READ_OK   = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_NEW       = 3'd2,
    ST_REPLACED  = 3'd3,
    ST_DROPPED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_WRITE,
    S_RD_ISSUE,
    S_RD_WAIT
  } state_t;

endpackage

`default_nettype wire

>>> hdl/mrukl_ram.sv
// generic single write port ram with registered read
`default_nettype none

module mrukl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/mru_keyed_record_list.sv
// most recent first keyed record list with oldest record eviction
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid in_stall func record_key record_payload | into block
//          | item_index                                     |
//  out     | out_valid out_stall status out_key out_payload  | out of block
//
// a store walks the recency order one entry a cycle through the record ram
// (one read port, one compare unit), stopping at a key match on a hit and
// after the last held entry on a miss, then writes the record to the front
// a read fetches a held position from the ram; one not held is not found
// one request at a time; in_stall is high from acceptance until the result
// is loaded into the output register, which then waits on out_stall alone
// synchronous reset empties the list and restores the slot order; no sweep
`default_nettype none

module mru_keyed_record_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] record_key,
  input  logic [63:0] record_payload,
  input  logic [7:0]  item_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] out_key,
  output logic [63:0] out_payload
);

  import mrukl_pkg::*;

  state_t                  state, state_next;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        ptr;
  logic                    cmp_valid;
  logic [IDX_W-1:0]        cmp_pos;
  logic [IDX_W-1:0]        hit_pos;
  logic [IDX_W-1:0]        order [DEPTH];
  logic [KEY_BITS-1:0]     req_key;
  logic [PAYLOAD_BITS-1:0] req_payload;
  logic [7:0]              req_index;
  status_t                 res_status;

  logic                    out_free;
  logic                    res_load;
  logic                    key_match;
  logic                    search_more;
  logic                    idx_hit;
  logic                    full;
  logic [IDX_W-1:0]        miss_pos;
  logic [IDX_W-1:0]        order_pos;
  logic [IDX_W-1:0]        slot;
  logic                    ram_we;
  logic                    ram_rd_en;
  logic [REC_W-1:0]        ram_rd_data;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_payload;

  assign out_free    = !out_valid || !out_stall;
  assign rd_key      = ram_rd_data[REC_W-1 -: KEY_BITS];
  assign rd_payload  = ram_rd_data[PAYLOAD_BITS-1:0];
  assign key_match   = cmp_valid && (rd_key == req_key);
  assign search_more = ptr < count;
  assign idx_hit     = CMP_W'(req_index) < CMP_W'(count);
  assign full        = count == CNT_W'(DEPTH);
  assign miss_pos    = full ? IDX_W'(DEPTH - 1) : count[IDX_W-1:0];
  assign slot        = order[order_pos];

  // record ram: key in the upper bits, payload below
  mrukl_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (slot),
    .wr_data ({req_key, req_payload}),
    .rd_en   (ram_rd_en),
    .rd_addr (slot),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (func == FUNC_READ) ? S_RD_ISSUE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (key_match || (!cmp_valid && !search_more)) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        if (idx_hit) begin
          state_next = S_RD_WAIT;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_RD_WAIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_rd_en = 1'b0;
    res_load  = 1'b0;
    order_pos = ptr[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_SEARCH: begin
        ram_rd_en = search_more;
      end
      S_WRITE: begin
        order_pos = hit_pos;
        ram_we    = out_free;
        res_load  = out_free;
      end
      S_RD_ISSUE: begin
        order_pos = req_index[IDX_W-1:0];
        ram_rd_en = idx_hit;
        res_load  = !idx_hit && out_free;
      end
      S_RD_WAIT: begin
        res_load = out_free;
      end
      default: begin
        order_pos = ptr[IDX_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j < DEPTH; j++) begin
        order[j] <= IDX_W'(j);
      end
    end else begin
      state <= state_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_key     <= record_key[KEY_BITS-1:0];
            req_payload <= record_payload[PAYLOAD_BITS-1:0];
            req_index   <= item_index;
            ptr         <= '0;
            cmp_valid   <= 1'b0;
          end
        end
        S_SEARCH: begin
          // issue position ptr, compare the one read last cycle
          cmp_valid <= search_more;
          cmp_pos   <= ptr[IDX_W-1:0];
          if (search_more) begin
            ptr <= ptr + 1'b1;
          end
          if (key_match) begin
            hit_pos    <= cmp_pos;
            res_status <= ST_REPLACED;
          end else if (!cmp_valid && !search_more) begin
            hit_pos    <= miss_pos;
            res_status <= full ? ST_DROPPED : ST_NEW;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            // rotate positions up to hit_pos, written slot goes to the front
            for (int j = 1; j < DEPTH; j++) begin
              if (j <= int'(hit_pos)) begin
                order[j] <= order[j-1];
              end
            end
            order[0] <= slot;
            if (res_status == ST_NEW) begin
              count <= count + 1'b1;
            end
            status      <= res_status;
            out_key     <= '0;
            out_payload <= '0;
          end
        end
        S_RD_ISSUE: begin
          if (!idx_hit && out_free) begin
            status      <= ST_NOT_FOUND;
            out_key     <= '0;
            out_payload <= '0;
          end
        end
        S_RD_WAIT: begin
          if (out_free) begin
            status      <= ST_READ_OK;
            out_key     <= 32'(rd_key);
            out_payload <= 64'(rd_payload);
          end
        end
        default: begin
          cmp_valid <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("record count beyond list depth");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |->
      $past(state == S_WRITE || state == S_RD_ISSUE || state == S_RD_WAIT))
    else $error("result loaded outside a finishing state");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && res_status == ST_DROPPED) |-> full)
    else $error("oldest record dropped while list not full");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> count == CNT_W'($past(count) + 1'b1))
    else $error("record count moved by more than one");
`endif

endmodule

`default_nettype wire
